// ----- src/twf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twf_pkg
// Shared types and constants for the twist-to-wheel-frames encoder.
// ----------------------------------------------------------------------------
package twf_pkg;

    // frame bytes
    localparam logic [7:0] SYNC_BYTE  = 8'hAA;
    localparam logic [7:0] ID_R_WHEEL = 8'h02;
    localparam logic [7:0] ID_L_WHEEL = 8'h01;
    localparam logic       MODE_DRIVE = 1'b1;
    localparam logic       MODE_HALT  = 1'b0;

    // speed code range
    localparam logic [4:0] CODE_SLOW  = 5'd16;
    localparam logic [4:0] CODE_FAST  = 5'd2;
    localparam logic [3:0] OFFSET_MAX = 4'd15;
    localparam logic [4:0] CODE_STOP  = 5'd0;

    // bytes per input: two frames of six
    localparam int unsigned FRAME_LEN = 6;
    localparam int unsigned WORD_CNT  = 2 * FRAME_LEN;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIN_THR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_TRACK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_LIMIT = 3'd5;

    // wheel command handed from the math pipeline to the byte sender
    typedef struct packed {
        logic       mode;
        logic       dir_r;
        logic [4:0] code_r;
        logic       dir_l;
        logic [4:0] code_l;
    } t_wheel_cmd;

endpackage

// ----- src/twist_to_wheel_frames_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twist_to_wheel_frames_core
// Differential-drive encoder: velocity command in, right/left motor frames out.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_lin_vel / i_ang_vel and pulse start; the word is
//   taken at a clock edge where start is high and busy is low.
//   Config channel: i_cfg_valid with i_cfg_index / i_cfg_data; o_cfg_ready is
//   always high. Write only while no command is in flight.
//   Output: twelve words per command (right frame, then left frame), one per
//   cycle, each marked by o_valid for a single cycle; o_frame_end flags byte
//   six of each frame and o_last the twelfth word.
// Path: an accepted command passes six register stages of math, then the
//   byte sender registers it; the twelve words follow back to back.
// Throughput: set by the one-word-per-cycle byte sender, which takes the next
//   command on its last word. The math pipeline buffers up to six further
//   commands; busy rises when all stages are full and the sender is not ready.
// Reset: synchronous, active low; empties the pipeline and sender and loads
//   the register defaults. The receiver cannot stall the output.
// ----------------------------------------------------------------------------
module twist_to_wheel_frames_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // command
    input  logic                             start,
    output logic                             busy,
    input  logic signed [15:0]               i_lin_vel,
    input  logic signed [15:0]               i_ang_vel,
    // configuration
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [twf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [15:0]                      i_cfg_data,
    // frame bytes
    output logic                             o_valid,
    output logic [7:0]                       o_tx_byte,
    output logic                             o_frame_end,
    output logic                             o_last
);

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic logic signed [15:0] sat16(input logic signed [20:0] x);
        if (x > 21'sd32767) begin
            return 16'sh7FFF;
        end else if (x < -21'sd32768) begin
            return 16'sh8000;
        end
        return x[15:0];
    endfunction

    function automatic logic [15:0] abs16(input logic signed [15:0] x);
        return x[15] ? 16'(-x) : 16'(x);
    endfunction

    // speed code from the rounded magnitude product
    function automatic logic [4:0] speed_code(input logic [31:0] prod);
        logic [32:0] sum;
        logic [12:0] off;
        logic [3:0]  off_cap;
        logic [4:0]  code;
        sum     = {1'b0, prod} + 33'h0_0008_0000;
        off     = sum[32:20];
        off_cap = (off > 13'(twf_pkg::OFFSET_MAX)) ? twf_pkg::OFFSET_MAX : off[3:0];
        code    = twf_pkg::CODE_SLOW - {1'b0, off_cap};
        if (code < twf_pkg::CODE_FAST) begin
            code = twf_pkg::CODE_FAST;
        end
        return code;
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [14:0] r_stop_thr;
    logic [14:0] r_lin_thr;
    logic [14:0] r_spin_gain;
    logic [14:0] r_half_track;
    logic [15:0] r_speed_scl;
    logic [4:0]  r_turn_limit;
    logic        cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_thr   <= 15'd41;
            r_lin_thr    <= 15'd205;
            r_spin_gain  <= 15'd12288;
            r_half_track <= 15'd344;
            r_speed_scl  <= 16'd6400;
            r_turn_limit <= 5'd6;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                twf_pkg::CFG_STOP_THR:   r_stop_thr   <= i_cfg_data[14:0];
                twf_pkg::CFG_LIN_THR:    r_lin_thr    <= i_cfg_data[14:0];
                twf_pkg::CFG_SPIN_GAIN:  r_spin_gain  <= i_cfg_data[14:0];
                twf_pkg::CFG_HALF_TRACK: r_half_track <= i_cfg_data[14:0];
                twf_pkg::CFG_SPEED_SCL:  r_speed_scl  <= i_cfg_data;
                twf_pkg::CFG_TURN_LIMIT: r_turn_limit <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stall chain: a stage loads when it is empty or moves on
    // ------------------------------------------------------------------
    logic r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld, r_f_vld;
    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f;
    logic tx_ready;
    logic in_acc;

    assign rdy_f  = !r_f_vld || tx_ready;
    assign rdy_e  = !r_e_vld || rdy_f;
    assign rdy_d  = !r_d_vld || rdy_e;
    assign rdy_c  = !r_c_vld || rdy_d;
    assign rdy_b  = !r_b_vld || rdy_c;
    assign rdy_a  = !r_a_vld || rdy_b;
    assign busy   = !rdy_a;
    assign in_acc = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else begin
            if (rdy_a) r_a_vld <= in_acc;
            if (rdy_b) r_b_vld <= r_a_vld;
            if (rdy_c) r_c_vld <= r_b_vld;
            if (rdy_d) r_d_vld <= r_c_vld;
            if (rdy_e) r_e_vld <= r_d_vld;
            if (rdy_f) r_f_vld <= r_e_vld;
        end
    end

    // ------------------------------------------------------------------
    // stage A: capture, stop and turn-in-place decisions
    // ------------------------------------------------------------------
    logic signed [15:0] r_a_v, r_a_w;
    logic               r_a_stop, r_a_inpl;
    logic [15:0]        in_av, in_aw;

    assign in_av = abs16(i_lin_vel);
    assign in_aw = abs16(i_ang_vel);

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_v    <= i_lin_vel;
            r_a_w    <= i_ang_vel;
            r_a_stop <= (in_av < {1'b0, r_stop_thr}) && (in_aw < {1'b0, r_stop_thr});
            r_a_inpl <= (in_av < {1'b0, r_lin_thr}) && (in_aw >= {1'b0, r_stop_thr});
        end
    end

    // ------------------------------------------------------------------
    // stage B: w * spin gain
    // ------------------------------------------------------------------
    logic signed [30:0] r_b_p;
    logic signed [15:0] r_b_v, r_b_w;
    logic               r_b_stop, r_b_inpl;
    logic signed [15:0] gain_s;
    logic signed [31:0] gain_prod;

    assign gain_s    = $signed({1'b0, r_spin_gain});
    assign gain_prod = r_a_w * gain_s;

    always_ff @(posedge i_clk) begin
        if (rdy_b) begin
            r_b_p    <= gain_prod[30:0];
            r_b_v    <= r_a_v;
            r_b_w    <= r_a_w;
            r_b_stop <= r_a_stop;
            r_b_inpl <= r_a_inpl;
        end
    end

    // ------------------------------------------------------------------
    // stage C: for turn-in-place, round and saturate the boosted turn rate
    // ------------------------------------------------------------------
    logic signed [15:0] r_c_v, r_c_w;
    logic               r_c_stop, r_c_inpl;
    logic signed [31:0] gain_rnd;
    logic signed [19:0] gain_q;

    assign gain_rnd = {r_b_p[30], r_b_p} + 32'sd2048;
    assign gain_q   = gain_rnd[31:12];

    always_ff @(posedge i_clk) begin
        if (rdy_c) begin
            r_c_w    <= r_b_inpl ? sat16({gain_q[19], gain_q}) : r_b_w;
            r_c_v    <= r_b_v;
            r_c_stop <= r_b_stop;
            r_c_inpl <= r_b_inpl;
        end
    end

    // ------------------------------------------------------------------
    // stage D: w * half_track
    // ------------------------------------------------------------------
    logic signed [30:0] r_d_p;
    logic signed [15:0] r_d_v;
    logic               r_d_stop, r_d_inpl;
    logic signed [15:0] track_s;
    logic signed [31:0] track_prod;

    assign track_s    = $signed({1'b0, r_half_track});
    assign track_prod = r_c_w * track_s;

    always_ff @(posedge i_clk) begin
        if (rdy_d) begin
            r_d_p    <= track_prod[30:0];
            r_d_v    <= r_c_v;
            r_d_stop <= r_c_stop;
            r_d_inpl <= r_c_inpl;
        end
    end

    // ------------------------------------------------------------------
    // stage E: wheel speeds v +/- t, saturated
    // ------------------------------------------------------------------
    logic signed [15:0] r_e_vr, r_e_vl;
    logic               r_e_stop, r_e_inpl;
    logic signed [31:0] track_rnd;
    logic signed [19:0] t_q;
    logic signed [20:0] sum_r, sum_l;

    assign track_rnd = {r_d_p[30], r_d_p} + 32'sd2048;
    assign t_q       = track_rnd[31:12];
    assign sum_r     = 21'(r_d_v) + 21'(t_q);
    assign sum_l     = 21'(r_d_v) - 21'(t_q);

    always_ff @(posedge i_clk) begin
        if (rdy_e) begin
            r_e_vr   <= sat16(sum_r);
            r_e_vl   <= sat16(sum_l);
            r_e_stop <= r_d_stop;
            r_e_inpl <= r_d_inpl;
        end
    end

    // ------------------------------------------------------------------
    // stage F: |speed| * speed_scale for both wheels
    // ------------------------------------------------------------------
    logic [31:0] r_f_pr, r_f_pl;
    logic        r_f_neg_r, r_f_neg_l;
    logic        r_f_stop, r_f_inpl;

    always_ff @(posedge i_clk) begin
        if (rdy_f) begin
            r_f_pr    <= abs16(r_e_vr) * r_speed_scl;
            r_f_pl    <= abs16(r_e_vl) * r_speed_scl;
            r_f_neg_r <= r_e_vr[15];
            r_f_neg_l <= r_e_vl[15];
            r_f_stop  <= r_e_stop;
            r_f_inpl  <= r_e_inpl;
        end
    end

    // ------------------------------------------------------------------
    // codes and frame fields, handed to the byte sender
    // ------------------------------------------------------------------
    twf_pkg::t_wheel_cmd cmd;
    logic [4:0]          code_r, code_l;

    assign code_r = speed_code(r_f_pr);
    assign code_l = speed_code(r_f_pl);

    always_comb begin
        if (r_f_stop) begin
            cmd.mode   = twf_pkg::MODE_HALT;
            cmd.dir_r  = 1'b0;
            cmd.code_r = twf_pkg::CODE_STOP;
            cmd.dir_l  = 1'b1;
            cmd.code_l = twf_pkg::CODE_STOP;
        end else begin
            cmd.mode   = twf_pkg::MODE_DRIVE;
            cmd.dir_r  = r_f_neg_r;
            cmd.dir_l  = !r_f_neg_l;
            cmd.code_r = (r_f_inpl && (code_r > r_turn_limit)) ? r_turn_limit : code_r;
            cmd.code_l = (r_f_inpl && (code_l > r_turn_limit)) ? r_turn_limit : code_l;
        end
    end

    twf_frame_tx u_tx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (r_f_vld),
        .i_cmd       (cmd),
        .o_cmd_ready (tx_ready),
        .o_valid     (o_valid),
        .o_tx_byte   (o_tx_byte),
        .o_frame_end (o_frame_end),
        .o_last      (o_last)
    );

endmodule

// ----- src/twf_frame_tx.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twf_frame_tx
// Byte sender: turns one wheel command into two 6-byte motor frames, one
// word per cycle, and takes the next command on its final byte.
// ----------------------------------------------------------------------------
module twf_frame_tx (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  twf_pkg::t_wheel_cmd i_cmd,
    output logic                o_cmd_ready,
    output logic                o_valid,
    output logic [7:0]          o_tx_byte,
    output logic                o_frame_end,
    output logic                o_last
);

    localparam int unsigned CNT_W = $clog2(twf_pkg::WORD_CNT);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(twf_pkg::WORD_CNT - 1);
    localparam logic [CNT_W-1:0] CNT_SPLIT = CNT_W'(twf_pkg::FRAME_LEN);

    // byte positions inside a frame
    localparam logic [2:0] POS_SYNC = 3'd0;
    localparam logic [2:0] POS_ID   = 3'd1;
    localparam logic [2:0] POS_MODE = 3'd2;
    localparam logic [2:0] POS_DIR  = 3'd3;
    localparam logic [2:0] POS_PAD  = 3'd4;
    localparam logic [2:0] POS_CODE = 3'd5;

    logic                r_act;
    logic [CNT_W-1:0]    r_cnt;
    twf_pkg::t_wheel_cmd r_cmd;

    logic             take;
    logic             is_right;
    logic [CNT_W-1:0] pos_full;
    logic [2:0]       pos;

    assign o_cmd_ready = !r_act || (r_cnt == CNT_LAST);
    assign take        = i_cmd_valid && o_cmd_ready;

    // word counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_cnt <= '0;
        end else if (take) begin
            r_act <= 1'b1;
            r_cnt <= '0;
        end else if (r_act) begin
            if (r_cnt == CNT_LAST) begin
                r_act <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= i_cmd;
        end
    end

    // byte select
    assign is_right = (r_cnt < CNT_SPLIT);
    assign pos_full = is_right ? r_cnt : (r_cnt - CNT_SPLIT);
    assign pos      = pos_full[2:0];

    always_comb begin
        case (pos)
            POS_SYNC: o_tx_byte = twf_pkg::SYNC_BYTE;
            POS_ID:   o_tx_byte = is_right ? twf_pkg::ID_R_WHEEL : twf_pkg::ID_L_WHEEL;
            POS_MODE: o_tx_byte = {7'd0, r_cmd.mode};
            POS_DIR:  o_tx_byte = {7'd0, is_right ? r_cmd.dir_r : r_cmd.dir_l};
            POS_PAD:  o_tx_byte = 8'd0;
            POS_CODE: o_tx_byte = {3'd0, is_right ? r_cmd.code_r : r_cmd.code_l};
            default:  o_tx_byte = 8'd0;
        endcase
    end

    assign o_valid     = r_act;
    assign o_frame_end = r_act && (pos == POS_CODE);
    assign o_last      = r_act && (r_cnt == CNT_LAST);

endmodule

// ----- src/twf_port_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twf_port_check
// Port-level checks on the frame stream of twist_to_wheel_frames_core.
// ----------------------------------------------------------------------------
module twf_port_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic [7:0] o_tx_byte,
    input logic       o_frame_end,
    input logic       o_last
);

    // flags only ride on a valid word
    a_flags_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_frame_end || o_last) |-> o_valid)
        else $error("frame flag without valid word");

    // a final word also ends a frame, and the first frame ended six words earlier
    a_last_frames: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> (o_frame_end && $past(o_frame_end, 6) && $past(o_valid, 11)))
        else $error("final word not at the end of two full frames");

    // the left frame follows the right one at once, starting with sync
    a_left_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_end && !o_last) |=>
            (o_valid && (o_tx_byte == twf_pkg::SYNC_BYTE)))
        else $error("left frame does not follow right frame");

    // stream goes quiet right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("word emitted after reset");

endmodule

bind twist_to_wheel_frames_core twf_port_check u_port_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .o_tx_byte   (o_tx_byte),
    .o_frame_end (o_frame_end),
    .o_last      (o_last)
);
